>>> rtl/core/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared constants of the line stepper
// Mode codes, configuration register indexes, register widths and resets.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

	localparam int COLOR_BITS     = 8;
	localparam int STRIDE_BITS    = 11;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = STRIDE_BITS;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAW_COLOR = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_STRIDE = 2'd1;

	localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 8'hff;
	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 11'd320;

endpackage

`default_nettype wire

>>> rtl/core/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper: Bresenham line engine for a byte framebuffer
// A load item (mode 0) gives two endpoints and sets up a line; each tick
// item (mode 1) emits one pixel write until the line is drawn.
//
// Channels: input items on in_valid/in_ready, pixel writes on
// out_valid/out_ready, register writes on cfg_valid/cfg_ready (index 0
// draw_color, index 1 row_stride; cfg_ready is always high).
// Path: a tick item goes through the input register, then the output
// register, which shows its pixel. A load item gives no pixel; a
// tick right behind it draws from the new line.
// Throughput: one item per cycle while no pixel waits on a low out_ready.
// The start row multiply lies between the input register and the line state
// registers; the error update and the address add feed the state registers.
// Reset: the engine is idle with no line; draw_color reads 255 and
// row_stride 320. Ticks while idle give no pixel.
// Stall: while out_ready is low with a pixel waiting, the input register
// holds and in_ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper #(
	parameter int COORD_BITS   = 10,
	parameter int ADDRESS_BITS = 20
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mode,
	input  wire logic [COORD_BITS-1:0]               start_x,
	input  wire logic [COORD_BITS-1:0]               start_y,
	input  wire logic [COORD_BITS-1:0]               end_x,
	input  wire logic [COORD_BITS-1:0]               end_y,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [ADDRESS_BITS-1:0]             pixel_address,
	output logic      [bls_pkg::COLOR_BITS-1:0]      pixel_value,
	output logic                                     last_pixel,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [bls_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int C = COORD_BITS;
	localparam int A = ADDRESS_BITS;

	logic [bls_pkg::COLOR_BITS-1:0]  draw_color_q;
	logic [bls_pkg::STRIDE_BITS-1:0] row_stride_q;

	logic         valid_s1;
	logic         mode_s1;
	logic [C-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic         ready_s1;

	logic [A-1:0]          init_address;
	logic [C:0]            init_left;
	logic signed [C+2:0]   init_error;
	logic [C+1:0]          init_add;
	logic [C+1:0]          init_subtract;
	logic [A-1:0]          init_straight;
	logic [A-1:0]          init_diagonal;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= bls_pkg::COLOR_RESET;
			row_stride_q <= bls_pkg::STRIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bls_pkg::CFG_DRAW_COLOR: draw_color_q <= cfg_data[bls_pkg::COLOR_BITS-1:0];
				bls_pkg::CFG_ROW_STRIDE: row_stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= mode;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
		end
	end

	bls_line_setup #(
		.COORD_BITS   (COORD_BITS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_setup (
		.start_x       (start_x_s1),
		.start_y       (start_y_s1),
		.end_x         (end_x_s1),
		.end_y         (end_y_s1),
		.row_stride    (row_stride_q),
		.init_address  (init_address),
		.init_left     (init_left),
		.init_error    (init_error),
		.init_add      (init_add),
		.init_subtract (init_subtract),
		.init_straight (init_straight),
		.init_diagonal (init_diagonal)
	);

	bls_stepper #(
		.COORD_BITS   (COORD_BITS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_stepper (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (valid_s1),
		.item_ready    (ready_s1),
		.item_mode     (mode_s1),
		.init_address  (init_address),
		.init_left     (init_left),
		.init_error    (init_error),
		.init_add      (init_add),
		.init_subtract (init_subtract),
		.init_straight (init_straight),
		.init_diagonal (init_diagonal),
		.draw_color    (draw_color_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last_pixel    (last_pixel)
	);

endmodule

`default_nettype wire

>>> rtl/core/bls_line_setup.sv
// ----------------------------------------------------------------------------
// bls_line_setup: line parameter calculation
// Orders the endpoints by row, derives deltas, direction, address steps,
// start address and initial error term for a load item.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_line_setup #(
	parameter int COORD_BITS   = 10,
	parameter int ADDRESS_BITS = 20
) (
	input  wire logic [COORD_BITS-1:0]            start_x,
	input  wire logic [COORD_BITS-1:0]            start_y,
	input  wire logic [COORD_BITS-1:0]            end_x,
	input  wire logic [COORD_BITS-1:0]            end_y,
	input  wire logic [bls_pkg::STRIDE_BITS-1:0]  row_stride,
	output logic      [ADDRESS_BITS-1:0]          init_address,
	output logic      [COORD_BITS:0]              init_left,
	output logic signed [COORD_BITS+2:0]          init_error,
	output logic      [COORD_BITS+1:0]            init_add,
	output logic      [COORD_BITS+1:0]            init_subtract,
	output logic      [ADDRESS_BITS-1:0]          init_straight,
	output logic      [ADDRESS_BITS-1:0]          init_diagonal
);

	localparam int C = COORD_BITS;
	localparam int A = ADDRESS_BITS;
	localparam int E = COORD_BITS + 3;

	logic                swap;
	logic [C-1:0]        x0, y0, x1, y1;
	logic signed [C:0]   dx_s;
	logic [C:0]          dx_neg;
	logic                neg;
	logic [C-1:0]        adx, dy, major, minor;
	logic                y_major;
	logic [A-1:0]        dir, stride_a, row_base;
	logic signed [E-1:0] major_e;

	always_comb begin
		swap     = (start_y >= end_y);
		x0       = swap ? end_x : start_x;
		y0       = swap ? end_y : start_y;
		x1       = swap ? start_x : end_x;
		y1       = swap ? start_y : end_y;
		dx_s     = $signed({1'b0, x1}) - $signed({1'b0, x0});
		dx_neg   = -dx_s;
		neg      = dx_s[C];
		adx      = neg ? dx_neg[C-1:0] : dx_s[C-1:0];
		dy       = y1 - y0;
		y_major  = (adx < dy);
		major    = y_major ? dy : adx;
		minor    = y_major ? adx : dy;
		dir      = neg ? {A{1'b1}} : A'(1);
		stride_a = A'(row_stride);
		row_base = A'(y0) * stride_a;
		major_e  = $signed({3'b000, major});

		init_address  = row_base + A'(x0);
		init_left     = {1'b0, major};
		init_error    = -major_e;
		init_add      = {1'b0, minor, 1'b0};
		init_subtract = {1'b0, major, 1'b0};
		init_straight = y_major ? stride_a : dir;
		init_diagonal = stride_a + dir;
	end

endmodule

`default_nettype wire

>>> rtl/core/bls_stepper.sv
// ----------------------------------------------------------------------------
// bls_stepper: line state and pixel output register
// Holds the midpoint error state, takes load and tick items and drives the
// registered pixel write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bls_stepper #(
	parameter int COORD_BITS   = 10,
	parameter int ADDRESS_BITS = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire logic                            item_mode,
	input  wire logic [ADDRESS_BITS-1:0]         init_address,
	input  wire logic [COORD_BITS:0]             init_left,
	input  wire logic signed [COORD_BITS+2:0]    init_error,
	input  wire logic [COORD_BITS+1:0]           init_add,
	input  wire logic [COORD_BITS+1:0]           init_subtract,
	input  wire logic [ADDRESS_BITS-1:0]         init_straight,
	input  wire logic [ADDRESS_BITS-1:0]         init_diagonal,
	input  wire logic [bls_pkg::COLOR_BITS-1:0]  draw_color,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ADDRESS_BITS-1:0]         pixel_address,
	output logic      [bls_pkg::COLOR_BITS-1:0]  pixel_value,
	output logic                                 last_pixel
);

	localparam int C = COORD_BITS;
	localparam int A = ADDRESS_BITS;
	localparam int E = COORD_BITS + 3;

	logic [A-1:0]        address_q;
	logic [C:0]          left_q;
	logic signed [E-1:0] error_q;
	logic [C+1:0]        add_q;
	logic [C+1:0]        subtract_q;
	logic [A-1:0]        straight_q;
	logic [A-1:0]        diagonal_q;
	logic                out_valid_q;

	logic                take;
	logic                is_load;
	logic                draws;
	logic signed [E-1:0] error_sum;
	logic                diag;

	always_comb begin
		item_ready = !out_valid_q || out_ready;
		take       = item_valid && item_ready;
		is_load    = (item_mode == bls_pkg::MODE_LOAD);
		draws      = !is_load && (left_q != '0);
		error_sum  = error_q + $signed({1'b0, add_q});
		diag       = (add_q != '0) && !error_sum[E-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q   <= '0;
			left_q      <= '0;
			error_q     <= '0;
			add_q       <= '0;
			subtract_q  <= '0;
			straight_q  <= '0;
			diagonal_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				out_valid_q <= take && draws;
			end
			if (take && is_load) begin
				address_q  <= init_address;
				left_q     <= init_left;
				error_q    <= init_error;
				add_q      <= init_add;
				subtract_q <= init_subtract;
				straight_q <= init_straight;
				diagonal_q <= init_diagonal;
			end else if (take && draws) begin
				address_q <= address_q + (diag ? diagonal_q : straight_q);
				error_q   <= diag ? (error_sum - $signed({1'b0, subtract_q})) : error_sum;
				left_q    <= left_q - (C+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && draws) begin
			pixel_address <= address_q;
			pixel_value   <= draw_color;
			last_pixel    <= (left_q == (C+1)'(1));
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
